// ===== sv/urhr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the undo/redo history ring
// no dependencies; used by the top module, the checker and the testbench

package urhr_pkg;

  // store geometry (DEPTH must be a power of two, the ring wraps by truncation)
  localparam int DEPTH      = 16;
  localparam int ENTRY_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CAP_W      = 5;

  // operation codes
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_PUSH    = 2'd1,
    OP_BACK    = 2'd2,
    OP_FORWARD = 2'd3
  } urhr_op_e;

  // input transaction
  typedef struct packed {
    urhr_op_e               op;
    logic [ENTRY_BITS-1:0]  entry_data;
  } urhr_in_t;

  // result transaction
  typedef struct packed {
    logic                   ok;
    logic [ENTRY_BITS-1:0]  current_entry;
    logic                   has_current;
    logic                   can_back;
    logic                   can_forward;
    logic [CAP_W-1:0]       entry_count;
  } urhr_out_t;

endpackage

// ===== sv/urhr_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module urhr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port (old data on same-address collision)
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/undo_redo_history_ring_top.sv =====
`timescale 1ns / 1ps
// An accepted transaction passes through the pending read stage and then the output register.
// A new transaction is not accepted while the snapshot ram read that follows each index
// update is in flight, nor while a stalled result holds the output register.
// Reset: history empty (count, cursor, oldest index zero), capacity 0 (full depth);
// the snapshot ram is not cleared, unwritten slots are never shown.
// Depends on urhr_pkg and urhr_ram.

module undo_redo_history_ring_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  urhr_pkg::urhr_in_t      in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output urhr_pkg::urhr_out_t     out_o,
  input  logic                    cfg_we_i,
  input  logic [urhr_pkg::CAP_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = urhr_pkg::IDX_W;
  localparam int CNT_W = urhr_pkg::CNT_W;
  localparam int CAP_W = urhr_pkg::CAP_W;
  localparam int CMP_W = CNT_W + CAP_W;

  // ring state
  logic [IDX_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] cursor_q, cursor_d;
  logic [CAP_W-1:0] capacity_q;

  // pending read stage
  logic                          pend_q;
  urhr_pkg::urhr_out_t           pend_res_q, pend_res_d;
  logic                          pend_fwd_q;
  logic [urhr_pkg::ENTRY_BITS-1:0] pend_data_q;

  // output register
  logic                  out_valid_q;
  urhr_pkg::urhr_out_t   out_q, out_d;

  logic                             in_acc;
  logic                             ok;
  logic                             we;
  logic [IDX_W-1:0]                 waddr;
  logic [IDX_W-1:0]                 raddr;
  logic [urhr_pkg::ENTRY_BITS-1:0]  rdata;
  logic [CNT_W-1:0]                 cap_eff;
  logic [CNT_W:0]                   n_new;
  logic [CNT_W:0]                   n_drop;
  logic [CNT_W-1:0]                 n_fin;

  // accept only when no read is in flight and the output slot frees up
  assign in_stall_o = pend_q || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // effective capacity: zero or oversize saturates at the depth
  always_comb begin
    if (capacity_q == '0 || CMP_W'(capacity_q) > CMP_W'(urhr_pkg::DEPTH)) begin
      cap_eff = CNT_W'(urhr_pkg::DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_q);
    end
  end

  // next ring indices, store write and result flags
  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    ok       = 1'b0;
    we       = 1'b0;
    waddr    = oldest_q + cursor_q + IDX_W'(1);
    n_new    = (CNT_W+1)'(cursor_q) + (CNT_W+1)'(2);
    n_drop   = n_new - (CNT_W+1)'(cap_eff);
    n_fin    = n_new[CNT_W-1:0];
    unique case (in_i.op)
      urhr_pkg::OP_RESTART: begin
        oldest_d = '0;
        count_d  = CNT_W'(1);
        cursor_d = '0;
        waddr    = '0;
        we       = 1'b1;
        ok       = 1'b1;
      end
      urhr_pkg::OP_PUSH: begin
        if (count_q != '0) begin
          // entries after the cursor are dropped, oldest evicted past capacity
          if (n_new > (CNT_W+1)'(cap_eff)) begin
            oldest_d = oldest_q + n_drop[IDX_W-1:0];
            n_fin    = cap_eff;
          end
          count_d  = n_fin;
          cursor_d = IDX_W'(n_fin - CNT_W'(1));
          we       = 1'b1;
          ok       = 1'b1;
        end
      end
      urhr_pkg::OP_BACK: begin
        if (count_q != '0 && cursor_q != '0) begin
          cursor_d = cursor_q - IDX_W'(1);
          ok       = 1'b1;
        end
      end
      urhr_pkg::OP_FORWARD: begin
        if (count_q != '0 && CNT_W'(cursor_q) + CNT_W'(1) < count_q) begin
          cursor_d = cursor_q + IDX_W'(1);
          ok       = 1'b1;
        end
      end
      default: begin
      end
    endcase
    raddr = oldest_d + cursor_d;

    pend_res_d               = '0;
    pend_res_d.ok            = ok;
    pend_res_d.has_current   = (count_d != '0);
    pend_res_d.can_back      = (count_d != '0) && (cursor_d != '0);
    pend_res_d.can_forward   = (count_d != '0) && (CNT_W'(cursor_d) + CNT_W'(1) < count_d);
    pend_res_d.entry_count   = CAP_W'(count_d);
  end

  // snapshot store
  urhr_ram #(
    .WIDTH (urhr_pkg::ENTRY_BITS),
    .DEPTH (urhr_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && we),
    .waddr_i (waddr),
    .wdata_i (in_i.entry_data),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ring state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q   <= '0;
      count_q    <= '0;
      cursor_q   <= '0;
      capacity_q <= '0;
    end else begin
      if (in_acc) begin
        oldest_q <= oldest_d;
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  // pending stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= in_acc;
    end
  end

  // pending stage payload; the written word is forwarded past the ram
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_res_q  <= pend_res_d;
      pend_fwd_q  <= we;
      pend_data_q <= in_i.entry_data;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result with the current entry filled in
  always_comb begin
    out_d = pend_res_q;
    if (!pend_res_q.has_current) begin
      out_d.current_entry = '0;
    end else if (pend_fwd_q) begin
      out_d.current_entry = pend_data_q;
    end else begin
      out_d.current_entry = rdata;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/urhr_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the undo/redo history ring
// depends on urhr_pkg; bound to undo_redo_history_ring_top

module urhr_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_o,
  input  logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  urhr_pkg::urhr_out_t     out_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted transaction blocks the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a read is in flight");

  // every accepted transaction yields a valid result after the pending stage and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after accept");

  // an empty history shows no count, no neighbors and no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.has_current |->
      out_o.entry_count == '0 && !out_o.can_back && !out_o.can_forward &&
      out_o.current_entry == '0)
    else $error("empty history shows state");

  // a held history has at least one entry and at most the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.has_current |->
      out_o.entry_count != '0 &&
      out_o.entry_count <= urhr_pkg::CAP_W'(urhr_pkg::DEPTH))
    else $error("entry count out of range");

endmodule

bind undo_redo_history_ring_top urhr_checker u_urhr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ===== tb/sv/urhr_history_monitor.sv =====
`timescale 1ns / 1ps
// transaction monitor for the undo/redo history ring: predicts each result and compares it
// depends on urhr_pkg; instantiated beside the block by tb_undo_redo_history_ring_top

module urhr_history_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  urhr_pkg::urhr_in_t         in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  urhr_pkg::urhr_out_t        out_data_i,
  input  logic                       cfg_we_i,
  input  logic [urhr_pkg::CAP_W-1:0] cfg_wdata_i,
  output int                         mismatch_count_o,
  output int                         views_outstanding_o
);

  localparam int DEPTH      = urhr_pkg::DEPTH;
  localparam int ENTRY_BITS = urhr_pkg::ENTRY_BITS;
  localparam int IDX_W      = urhr_pkg::IDX_W;
  localparam int CNT_W      = urhr_pkg::CNT_W;
  localparam int CAP_W      = urhr_pkg::CAP_W;

  // predicted history state
  logic [ENTRY_BITS-1:0] snap_ring [DEPTH];
  logic [IDX_W-1:0]      oldest_idx;
  logic [CNT_W-1:0]      held_cnt;
  logic [IDX_W-1:0]      cursor_off;
  logic [CAP_W-1:0]      capacity_reg;

  // predicted history views, oldest first
  urhr_pkg::urhr_out_t history_view_q [$];
  urhr_pkg::urhr_out_t want_view;
  logic                view_bad;

  initial begin
    mismatch_count_o    = 0;
    views_outstanding_o = 0;
  end

  // apply one operation to the predicted history and return the view after it
  function automatic urhr_pkg::urhr_out_t advance_history(urhr_pkg::urhr_in_t txn);
    int                  n;
    int                  cap;
    logic                ok;
    urhr_pkg::urhr_out_t view;
    ok = 1'b0;
    case (txn.op)
      urhr_pkg::OP_RESTART: begin
        oldest_idx   = '0;
        snap_ring[0] = txn.entry_data;
        held_cnt     = CNT_W'(1);
        cursor_off   = '0;
        ok           = 1'b1;
      end
      urhr_pkg::OP_PUSH: begin
        if (held_cnt != 0) begin
          // everything after the cursor is dropped, new entry goes right after it
          n   = int'(cursor_off) + 1;
          cap = (capacity_reg == 0 || capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
          snap_ring[IDX_W'((int'(oldest_idx) + n) % DEPTH)] = txn.entry_data;
          n++;
          // evict oldest entries until the count fits
          if (n > cap) begin
            oldest_idx = IDX_W'((int'(oldest_idx) + n - cap) % DEPTH);
            n          = cap;
          end
          held_cnt   = CNT_W'(n);
          cursor_off = IDX_W'(n - 1);
          ok         = 1'b1;
        end
      end
      urhr_pkg::OP_BACK: begin
        if (held_cnt != 0 && cursor_off > 0) begin
          cursor_off = cursor_off - 1'b1;
          ok         = 1'b1;
        end
      end
      default: begin
        if (held_cnt != 0 && int'(cursor_off) + 1 < int'(held_cnt)) begin
          cursor_off = cursor_off + 1'b1;
          ok         = 1'b1;
        end
      end
    endcase
    view.ok            = ok;
    view.has_current   = (held_cnt != 0);
    view.current_entry = (held_cnt != 0) ?
                         snap_ring[IDX_W'((int'(oldest_idx) + int'(cursor_off)) % DEPTH)] :
                         '0;
    view.can_back      = (held_cnt != 0 && cursor_off > 0);
    view.can_forward   = (held_cnt != 0 && int'(cursor_off) + 1 < int'(held_cnt));
    view.entry_count   = CAP_W'(held_cnt);
    return view;
  endfunction

  // report one differing field
  function automatic logic field_differs(string name, logic [ENTRY_BITS-1:0] want,
                                         logic [ENTRY_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // track configuration, compare results, then predict new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_idx   = '0;
      held_cnt     = '0;
      cursor_off   = '0;
      capacity_reg = '0;
      history_view_q.delete();
    end else begin
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (history_view_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          mismatch_count_o++;
        end else begin
          want_view = history_view_q.pop_front();
          view_bad  = field_differs("ok", ENTRY_BITS'(want_view.ok),
                                    ENTRY_BITS'(out_data_i.ok))
                    | field_differs("current_entry", want_view.current_entry,
                                    out_data_i.current_entry)
                    | field_differs("has_current", ENTRY_BITS'(want_view.has_current),
                                    ENTRY_BITS'(out_data_i.has_current))
                    | field_differs("can_back", ENTRY_BITS'(want_view.can_back),
                                    ENTRY_BITS'(out_data_i.can_back))
                    | field_differs("can_forward", ENTRY_BITS'(want_view.can_forward),
                                    ENTRY_BITS'(out_data_i.can_forward))
                    | field_differs("entry_count", ENTRY_BITS'(want_view.entry_count),
                                    ENTRY_BITS'(out_data_i.entry_count));
          if (view_bad) begin
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        history_view_q.push_back(advance_history(in_data_i));
      end
    end
    views_outstanding_o <= history_view_q.size();
  end

endmodule

// ===== tb/sv/tb_undo_redo_history_ring_top.sv =====
`timescale 1ns / 1ps
// testbench top for the undo/redo history ring: clock, reset, stimulus and verdict
// depends on urhr_pkg, undo_redo_history_ring_top and urhr_history_monitor

module tb_undo_redo_history_ring_top;

  localparam int PHASE_ITEMS    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int ENTRY_BITS     = urhr_pkg::ENTRY_BITS;
  localparam int CAP_W          = urhr_pkg::CAP_W;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  urhr_pkg::urhr_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  urhr_pkg::urhr_out_t out_data;
  logic                cfg_we    = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;

  int mismatch_count;
  int views_outstanding;
  int stuck_cycles = 0;
  int stall_cycle  = 0;
  int stall_pct    = 0;

  logic [CAP_W-1:0] phase_caps [8] = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd17, 5'd3, 5'd0, 5'd9};

  undo_redo_history_ring_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  urhr_history_monitor u_monitor (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_data_i           (in_data),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_data_i          (out_data),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .mismatch_count_o    (mismatch_count),
    .views_outstanding_o (views_outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // present one transaction and hold it until accepted
  task automatic send(input urhr_pkg::urhr_op_e op, input logic [ENTRY_BITS-1:0] word);
    in_valid <= 1'b1;
    in_data  <= '{op: op, entry_data: word};
    do @(posedge clk); while (in_stall);
  endtask

  // sender gap: in_valid held low for the cycles given
  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (views_outstanding != 0);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly pushes and navigation, restarts now and then
  function automatic urhr_pkg::urhr_op_e random_op();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return urhr_pkg::OP_RESTART;
    if (r < 50) return urhr_pkg::OP_PUSH;
    if (r < 78) return urhr_pkg::OP_BACK;
    return urhr_pkg::OP_FORWARD;
  endfunction

  // snapshot words, with the all-zero and all-one words mixed in
  function automatic logic [ENTRY_BITS-1:0] random_word();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // random transactions sent in bursts with gaps
  task automatic run_phase(input int items);
    int burst;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < items; i++) begin
      send(random_op(), random_word());
      burst--;
      if ($urandom_range(79) == 0) begin
        drain();
      end else if (burst == 0) begin
        hold_off($urandom_range(1, 6));
        burst = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
    end
  endtask

  // reset, directed cases, random phases, verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capacity('0);

    // navigation and push on an empty history
    send(urhr_pkg::OP_PUSH, 32'hDEAD_BEEF);
    send(urhr_pkg::OP_BACK, 32'h0000_0000);
    send(urhr_pkg::OP_FORWARD, 32'hFFFF_FFFF);
    // single entry: both directions fail
    send(urhr_pkg::OP_RESTART, 32'hFFFF_FFFF);
    send(urhr_pkg::OP_BACK, 32'h1234_5678);
    send(urhr_pkg::OP_FORWARD, 32'h8765_4321);
    send(urhr_pkg::OP_PUSH, 32'h0000_0000);
    send(urhr_pkg::OP_PUSH, 32'h8000_0000);
    send(urhr_pkg::OP_BACK, 32'h0);
    send(urhr_pkg::OP_FORWARD, 32'h0);
    send(urhr_pkg::OP_BACK, 32'h0);
    // push from the middle drops the newer entry
    send(urhr_pkg::OP_PUSH, 32'h0000_0001);
    // fill the ring and push past full depth
    for (int i = 0; i < 14; i++) begin
      send(urhr_pkg::OP_PUSH, random_word());
    end
    // capacity lowered below the held count, then a push
    write_capacity(5'd3);
    send(urhr_pkg::OP_PUSH, 32'h5A5A_A5A5);

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stall pattern, its density drawn anew at random from 0, 25, 50 or 90 percent
  always @(posedge clk) begin
    stall_cycle++;
    if (stall_cycle % 256 == 0) begin
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
